// ===== sv/xalu_pkg.sv =====
// Package for the x86 integer ALU: opcodes, sizes, sequencer states, helpers.
package xalu_pkg;

    localparam int DataWidth = 32;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBB  = 5'd3,
        OP_AND  = 5'd4,
        OP_OR   = 5'd5,
        OP_XOR  = 5'd6,
        OP_NOT  = 5'd7,
        OP_NEG  = 5'd8,
        OP_SHL  = 5'd9,
        OP_SHR  = 5'd10,
        OP_SAR  = 5'd11,
        OP_MUL  = 5'd12,
        OP_IMUL = 5'd13,
        OP_DIV  = 5'd14,
        OP_IDIV = 5'd15,
        OP_MOD  = 5'd16,
        OP_IMOD = 5'd17
    } op_t;

    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } state_t;

    // Kind of iterative job handed to the shared unit
    typedef enum logic [1:0] {
        JOB_SHIFT,
        JOB_MUL,
        JOB_DIV
    } job_t;

    typedef struct packed {
        logic start;
        job_t job;
    } unit_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    // Mask of the operand size
    function automatic logic [63:0] size_mask(input logic [1:0] sel);
        case (sel)
            SIZE_8:  size_mask = 64'h0000_0000_0000_00ff;
            SIZE_16: size_mask = 64'h0000_0000_0000_ffff;
            default: size_mask = 64'h0000_0000_ffff_ffff;
        endcase
    endfunction

    // Sign bit of a value at the operand size
    function automatic logic top_bit(input logic [63:0] v, input logic [1:0] sel);
        case (sel)
            SIZE_8:  top_bit = v[7];
            SIZE_16: top_bit = v[15];
            default: top_bit = v[31];
        endcase
    endfunction

    // Sign extend from the operand size to 64 bits
    function automatic logic [63:0] sext64(input logic [63:0] v, input logic [1:0] sel);
        logic [63:0] m;
        m = size_mask(sel);
        sext64 = (v & m) | (top_bit(v, sel) ? ~m : 64'd0);
    endfunction

endpackage

// ===== sv/xalu_unit.sv =====
// Shared iterative unit: one shift step, one shift-add step or one restoring divide step a cycle.
module xalu_unit
    import xalu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  unit_ctl_t   ctl,
    input  logic [63:0] opa,     // shift operand, multiplicand, or dividend magnitude
    input  logic [63:0] opb,     // multiplier, or divisor magnitude
    input  logic [5:0]  steps,   // shift count, 1..31 for shifts
    input  logic        fill,    // bit shifted in from the left for right shifts
    input  logic        left,    // shift direction
    output unit_sts_t   sts,
    output logic [63:0] acc,     // shift result / product / quotient
    output logic [63:0] rem,     // remainder
    output logic        last_out // last bit shifted out
);

    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    job_t        job_reg, job_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] r_reg, r_next;
    logic        fill_reg, fill_next;
    logic        left_reg, left_next;
    logic        out_reg, out_next;
    logic [64:0] trial;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            job_reg  <= JOB_SHIFT;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            job_reg  <= job_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        r_reg    <= r_next;
        fill_reg <= fill_next;
        left_reg <= left_next;
        out_reg  <= out_next;
    end

    assign trial = {r_reg, a_reg[63]} - {1'b0, b_reg};

    // One step per cycle
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        job_next  = job_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        fill_next = fill_reg;
        left_next = left_reg;
        out_next  = out_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            job_next  = ctl.job;
            a_next    = opa;
            b_next    = opb;
            r_next    = '0;
            fill_next = fill;
            left_next = left;
            out_next  = 1'b0;
            case (ctl.job)
                JOB_SHIFT: cnt_next = {1'b0, steps};
                // All 64 multiplier bits, so sign-extended operands give the signed product
                JOB_MUL:   cnt_next = 7'd64;
                default:   cnt_next = 7'd64;
            endcase
        end
        else if (busy_reg)
        begin
            case (job_reg)
                JOB_SHIFT:
                begin
                    if (left_reg)
                    begin
                        out_next = a_reg[63];
                        a_next   = {a_reg[62:0], 1'b0};
                    end
                    else
                    begin
                        out_next = a_reg[0];
                        a_next   = {fill_reg, a_reg[63:1]};
                    end
                end
                JOB_MUL:
                begin
                    // r holds the product; a is the multiplicand moving left
                    if (b_reg[0])
                        r_next = r_reg + a_reg;
                    a_next = {a_reg[62:0], 1'b0};
                    b_next = {1'b0, b_reg[63:1]};
                end
                default:
                begin
                    // Restoring divide: r is the partial remainder, a the quotient
                    if (!trial[64])
                    begin
                        r_next = trial[63:0];
                        a_next = {a_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        r_next = {r_reg[62:0], a_reg[63]};
                        a_next = {a_reg[62:0], 1'b0};
                    end
                end
            endcase
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign acc      = (job_reg == JOB_MUL) ? r_reg : a_reg;
    assign rem      = r_reg;
    assign last_out = out_reg;

    // A job never starts while one is running
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> !ctl.start)
        else $error("unit started while busy");
    // Done follows the end of a busy stretch
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> $past(busy_reg))
        else $error("done without work");
    // Count runs out exactly when busy ends
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !ctl.start && cnt_reg == 7'd1) |=> !busy_reg)
        else $error("busy past the count");

endmodule

// ===== sv/x86_integer_alu_with_flags.sv =====
// Top level of the x86 integer ALU with flags: sequencer, flag state and stream ports.
// Sequence: an accepted input goes to ST_FIX, which finishes simple ops and launches shifts (count 1..31),
//   mul/imul and the div family in the shared unit (64 one-bit steps); the result is shown in ST_DONE.
// Throughput: one transaction at a time; the next input is taken the cycle after the result leaves.
// Nonzero shifts, multiplies and divides by a nonzero divisor run through the one shared bit-serial unit.
// Reset (rst_n, async, active low) clears the flags and the sequencer; no pending output.
module x86_integer_alu_with_flags
    import xalu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // src[31:0], dest[95:32], size_sel[97:96], zero pad
    input  logic [4:0]   s_axis_tuser,  // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata   // result[63:0], cf, of, sf, zf, pf, div_error, pad
);

    state_t      state_reg, state_next;
    logic [4:0]  cmd_reg;
    logic [31:0] src_reg;
    logic [63:0] dest_reg;
    logic [1:0]  sel_reg;
    logic        cf_reg, cf_next, of_reg, of_next, sf_reg, sf_next;
    logic        zf_reg, zf_next, pf_reg, pf_next;
    logic [63:0] res_reg, res_next;
    logic        err_reg, err_next;
    logic        negq_reg, negq_next;
    unit_ctl_t   uctl;
    unit_sts_t   usts;
    logic [63:0] uopa, uopb, uacc, urem;
    logic [5:0]  usteps;
    logic        ufill, uleft, ulast;
    logic        in_fire;

    // Operand views at the operand size
    logic [63:0] m, a, b, sa, sb, sum, dif, md, ms, r_eff;
    logic [4:0]  n;
    logic        szp_upd, szp_en;
    logic [5:0]  wid;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_DONE);
    assign m_axis_tdata  = {2'b00, err_reg, pf_reg, zf_reg, sf_reg, of_reg, cf_reg, res_reg};

    // Capture the transaction
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg  <= s_axis_tuser;
            src_reg  <= s_axis_tdata[31:0];
            dest_reg <= s_axis_tdata[95:32];
            sel_reg  <= s_axis_tdata[97:96];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cf_reg <= 1'b0; of_reg <= 1'b0; sf_reg <= 1'b0;
            zf_reg <= 1'b0; pf_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cf_reg <= cf_next; of_reg <= of_next; sf_reg <= sf_next;
            zf_reg <= zf_next; pf_reg <= pf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        err_reg  <= err_next;
        negq_reg <= negq_next;
    end

    // Operand preparation
    always_comb
    begin
        m   = size_mask(sel_reg);
        a   = dest_reg & m;
        b   = {32'd0, src_reg} & m;
        sa  = sext64(a, sel_reg);
        sb  = sext64(b, sel_reg);
        md  = dest_reg[63] ? (64'd0 - dest_reg) : dest_reg;
        ms  = sb[63] ? (64'd0 - sb) : sb;
        n   = src_reg[4:0];
        case (sel_reg)
            SIZE_8:  wid = 6'd8;
            SIZE_16: wid = 6'd16;
            default: wid = 6'd32;
        endcase
        sum = a + b + {63'd0, (cmd_reg == OP_ADC) && cf_reg};
        dif = a - b - {63'd0, (cmd_reg == OP_SBB) && cf_reg};
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_fire) state_next = ST_FIX;
            ST_FIX:
            begin
                case (cmd_reg)
                    OP_SHL, OP_SHR, OP_SAR:
                        state_next = (n == 5'd0) ? ST_DONE : ST_SHIFT;
                    OP_MUL, OP_IMUL:
                        state_next = ST_MUL;
                    OP_DIV, OP_IDIV, OP_MOD, OP_IMOD:
                        state_next = (b == 64'd0) ? ST_DONE : ST_DIV;
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_SHIFT, ST_MUL, ST_DIV:
                if (usts.done) state_next = ST_DONE;
            ST_DONE:
                if (m_axis_tready) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Unit launch and outputs
    always_comb
    begin
        uctl.start = 1'b0;
        uctl.job   = JOB_SHIFT;
        uopa   = a;
        uopb   = b;
        usteps = {1'b0, n};
        ufill  = 1'b0;
        uleft  = 1'b0;
        cf_next = cf_reg; of_next = of_reg; sf_next = sf_reg;
        zf_next = zf_reg; pf_next = pf_reg;
        res_next  = res_reg;
        err_next  = err_reg;
        negq_next = negq_reg;
        szp_upd   = 1'b0;
        r_eff     = res_reg;
        if (state_reg == ST_FIX)
        begin
            err_next  = 1'b0;
            res_next  = 64'd0;
            negq_next = 1'b0;
            case (cmd_reg)
                OP_ADD, OP_ADC:
                begin
                    res_next = sum & m;
                    cf_next  = sum[wid];
                    of_next  = top_bit(~(a ^ b) & (a ^ (sum & m)), sel_reg);
                    szp_upd  = 1'b1;
                end
                OP_SUB, OP_SBB:
                begin
                    res_next = dif & m;
                    cf_next  = dif[63];
                    of_next  = top_bit((a ^ b) & (a ^ (dif & m)), sel_reg);
                    szp_upd  = 1'b1;
                end
                OP_AND, OP_OR, OP_XOR:
                begin
                    res_next = (cmd_reg == OP_AND) ? (a & b) :
                               (cmd_reg == OP_OR) ? (a | b) : (a ^ b);
                    cf_next  = 1'b0;
                    of_next  = 1'b0;
                    szp_upd  = 1'b1;
                end
                OP_NOT:
                    res_next = ~dest_reg & m;
                OP_NEG:
                begin
                    res_next = (64'd0 - a) & m;
                    cf_next  = (a != 64'd0);
                    of_next  = (a == ((m >> 1) + 64'd1));
                    szp_upd  = 1'b1;
                end
                OP_SHL, OP_SHR, OP_SAR:
                begin
                    res_next = a;
                    if (n == 5'd0)
                        szp_upd = 1'b1;
                    else
                    begin
                        uctl.start = 1'b1;
                        uctl.job   = JOB_SHIFT;
                        // Left shifts run with the operand at the top of the word
                        case (sel_reg)
                            SIZE_8:  uopa = (cmd_reg == OP_SHL) ? {a[7:0], 56'd0} : sa;
                            SIZE_16: uopa = (cmd_reg == OP_SHL) ? {a[15:0], 48'd0} : sa;
                            default: uopa = (cmd_reg == OP_SHL) ? {a[31:0], 32'd0} : sa;
                        endcase
                        if (cmd_reg == OP_SHR) uopa = a;
                        ufill = (cmd_reg == OP_SAR) && sa[63];
                        uleft = (cmd_reg == OP_SHL);
                    end
                end
                OP_MUL, OP_IMUL:
                begin
                    uctl.start = 1'b1;
                    uctl.job   = JOB_MUL;
                    uopa = (cmd_reg == OP_IMUL) ? sa : a;
                    uopb = (cmd_reg == OP_IMUL) ? sb : b;
                end
                OP_DIV, OP_IDIV, OP_MOD, OP_IMOD:
                begin
                    if (b == 64'd0)
                        err_next = 1'b1;
                    else
                    begin
                        uctl.start = 1'b1;
                        uctl.job   = JOB_DIV;
                        uopa = (cmd_reg == OP_DIV || cmd_reg == OP_MOD) ? dest_reg : md;
                        uopb = (cmd_reg == OP_DIV || cmd_reg == OP_MOD) ? b : ms;
                        negq_next = dest_reg[63] ^ sb[63];
                    end
                end
                default:
                    res_next = 64'd0;
            endcase
            r_eff = res_next;
        end
        else if (usts.done)
        begin
            case (cmd_reg)
                OP_SHL, OP_SHR, OP_SAR:
                begin
                    case (sel_reg)
                        SIZE_8:  r_eff = (cmd_reg == OP_SHL) ? {56'd0, uacc[63:56]} : uacc & m;
                        SIZE_16: r_eff = (cmd_reg == OP_SHL) ? {48'd0, uacc[63:48]} : uacc & m;
                        default: r_eff = (cmd_reg == OP_SHL) ? {32'd0, uacc[63:32]} : uacc & m;
                    endcase
                    cf_next = ulast;
                    // Left shift past the width has already shifted out zeros
                    if (cmd_reg == OP_SHL && {1'b0, n} > wid) cf_next = 1'b0;
                    szp_upd = 1'b1;
                end
                OP_MUL:
                begin
                    r_eff   = uacc;
                    cf_next = ((uacc >> wid) != 64'd0);
                    of_next = cf_next;
                end
                OP_IMUL:
                    r_eff = uacc;
                OP_DIV:  r_eff = uacc & m;
                OP_MOD:  r_eff = urem & m;
                OP_IDIV: r_eff = (negq_reg ? (64'd0 - uacc) : uacc) & m;
                default: r_eff = (dest_reg[63] ? (64'd0 - urem) : urem) & m;
            endcase
            res_next = r_eff;
        end
        szp_en = szp_upd;
        if (szp_en)
        begin
            sf_next = top_bit(r_eff, sel_reg);
            zf_next = (r_eff == 64'd0);
            pf_next = ~^r_eff[7:0];
        end
    end

    xalu_unit u_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (uctl),
        .opa      (uopa),
        .opb      (uopb),
        .steps    (usteps),
        .fill     (ufill),
        .left     (uleft),
        .sts      (usts),
        .acc      (uacc),
        .rem      (urem),
        .last_out (ulast)
    );

    // No input taken while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n) m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready with result pending");
    // The unit only runs in its work states
    assert property (@(posedge clk) disable iff (!rst_n)
        usts.busy |-> (state_reg == ST_SHIFT || state_reg == ST_MUL || state_reg == ST_DIV))
        else $error("unit busy outside work state");
    // Flags hold while waiting on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable({cf_reg, of_reg, sf_reg, zf_reg, pf_reg}))
        else $error("flags moved while stalled");

endmodule
